>>> sv/cir_pkg.sv
// shared types, codes and microprogram of the contact impulse resolver
`default_nettype none
package cir_pkg;

  localparam int PC_BITS = 7;
  localparam logic [PC_BITS-1:0] PROG_LAST = 7'd88;

  localparam logic [1:0] KIND_STATIC  = 2'd0;
  localparam logic [1:0] KIND_DYNAMIC = 2'd1;

  typedef enum logic [2:0] {
    OP_PASS, OP_ADD, OP_SUB, OP_MIN, OP_MAX, OP_MUL, OP_DIV, OP_LEN
  } alu_op_t;

  typedef enum logic [2:0] {
    A_IDLE, A_MUL, A_SQ1, A_SQ2, A_SQRT, A_DIV
  } alu_state_t;

  typedef enum logic [1:0] {
    S_IDLE, S_ISSUE, S_WAIT, S_FINISH
  } seq_state_t;

  typedef enum logic [4:0] {
    C_ALL, C_CC, C_CR, C_RC, C_RR, C_LENPOS, C_LENZ, C_RRX, C_RRY,
    C_IMP, C_IMP_AK1, C_IMP_BK1, C_IMP_AK0, C_IMP_BK0,
    C_COR, C_COR_AK1, C_COR_BK1
  } cond_t;

  typedef enum logic [5:0] {
    R_ZERO, R_ONE, R_SGNX, R_SGNY,
    R_AX, R_AY, R_AHW, R_AHH, R_AVX, R_AVY, R_AM, R_AE,
    R_BX, R_BY, R_BHW, R_BHH, R_BVX, R_BVY, R_BM, R_BE,
    R_CX, R_CY, R_CHW, R_RX, R_RY, R_RHW, R_RHH,
    R_DX, R_DY, R_T0, R_T1, R_T2, R_LEN, R_NX, R_NY, R_PEN, R_E,
    R_IM1, R_IM2, R_TOT, R_SEP,
    R_V0X, R_V0Y, R_V1X, R_V1Y, R_M0X, R_M0Y, R_M1X, R_M1Y
  } sel_t;

  typedef struct packed {
    cond_t   cond;
    alu_op_t op;
    sel_t    dst;
    sel_t    sa;
    sel_t    sb;
  } instr_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

  function automatic instr_t mk(cond_t c, alu_op_t o, sel_t d, sel_t a, sel_t b);
    instr_t i;
    i.cond = c;
    i.op   = o;
    i.dst  = d;
    i.sa   = a;
    i.sb   = b;
    return i;
  endfunction

  function automatic instr_t prog_at(logic [PC_BITS-1:0] pc);
    instr_t i;
    unique case (pc)
      // geometry: center offset
      7'd0:  i = mk(C_ALL, OP_SUB, R_DX, R_AX, R_BX);
      7'd1:  i = mk(C_ALL, OP_SUB, R_DY, R_AY, R_BY);
      // circle pair
      7'd2:  i = mk(C_CC, OP_LEN, R_LEN, R_DX, R_DY);
      7'd3:  i = mk(C_CC, OP_ADD, R_T0, R_AHW, R_BHW);
      7'd4:  i = mk(C_CC, OP_SUB, R_PEN, R_T0, R_LEN);
      // circle against rectangle, closest point by clamping
      7'd5:  i = mk(C_CR, OP_SUB, R_T0, R_RX, R_RHW);
      7'd6:  i = mk(C_CR, OP_ADD, R_T1, R_RX, R_RHW);
      7'd7:  i = mk(C_CR, OP_MAX, R_T0, R_CX, R_T0);
      7'd8:  i = mk(C_CR, OP_MIN, R_T0, R_T0, R_T1);
      7'd9:  i = mk(C_CR, OP_SUB, R_DX, R_CX, R_T0);
      7'd10: i = mk(C_CR, OP_SUB, R_T0, R_RY, R_RHH);
      7'd11: i = mk(C_CR, OP_ADD, R_T1, R_RY, R_RHH);
      7'd12: i = mk(C_CR, OP_MAX, R_T0, R_CY, R_T0);
      7'd13: i = mk(C_CR, OP_MIN, R_T0, R_T0, R_T1);
      7'd14: i = mk(C_CR, OP_SUB, R_DY, R_CY, R_T0);
      7'd15: i = mk(C_CR, OP_LEN, R_LEN, R_DX, R_DY);
      7'd16: i = mk(C_CR, OP_SUB, R_PEN, R_CHW, R_LEN);
      // unit normal
      7'd17: i = mk(C_LENPOS, OP_DIV, R_NX, R_DX, R_LEN);
      7'd18: i = mk(C_LENPOS, OP_DIV, R_NY, R_DY, R_LEN);
      7'd19: i = mk(C_LENZ, OP_PASS, R_NX, R_ZERO, R_ZERO);
      7'd20: i = mk(C_LENZ, OP_PASS, R_NY, R_ONE, R_ZERO);
      7'd21: i = mk(C_RC, OP_SUB, R_NX, R_ZERO, R_NX);
      7'd22: i = mk(C_RC, OP_SUB, R_NY, R_ZERO, R_NY);
      // rectangle pair
      7'd23: i = mk(C_RR, OP_SUB, R_T0, R_ZERO, R_DX);
      7'd24: i = mk(C_RR, OP_MAX, R_T0, R_DX, R_T0);
      7'd25: i = mk(C_RR, OP_ADD, R_T1, R_AHW, R_BHW);
      7'd26: i = mk(C_RR, OP_SUB, R_T0, R_T1, R_T0);
      7'd27: i = mk(C_RR, OP_SUB, R_T1, R_ZERO, R_DY);
      7'd28: i = mk(C_RR, OP_MAX, R_T1, R_DY, R_T1);
      7'd29: i = mk(C_RR, OP_ADD, R_T2, R_AHH, R_BHH);
      7'd30: i = mk(C_RR, OP_SUB, R_T1, R_T2, R_T1);
      7'd31: i = mk(C_RRX, OP_PASS, R_PEN, R_T0, R_ZERO);
      7'd32: i = mk(C_RRX, OP_PASS, R_NX, R_SGNX, R_ZERO);
      7'd33: i = mk(C_RRX, OP_PASS, R_NY, R_ZERO, R_ZERO);
      7'd34: i = mk(C_RRY, OP_PASS, R_PEN, R_T1, R_ZERO);
      7'd35: i = mk(C_RRY, OP_PASS, R_NX, R_ZERO, R_ZERO);
      7'd36: i = mk(C_RRY, OP_PASS, R_NY, R_SGNY, R_ZERO);
      // mass weighted restitution, inverse masses and initial velocities and moves
      7'd37: i = mk(C_ALL, OP_MUL, R_T0, R_AM, R_AE);
      7'd38: i = mk(C_ALL, OP_MUL, R_T1, R_BM, R_BE);
      7'd39: i = mk(C_ALL, OP_ADD, R_T0, R_T0, R_T1);
      7'd40: i = mk(C_ALL, OP_ADD, R_T1, R_AM, R_BM);
      7'd41: i = mk(C_ALL, OP_DIV, R_E, R_T0, R_T1);
      7'd42: i = mk(C_ALL, OP_DIV, R_IM1, R_ONE, R_AM);
      7'd43: i = mk(C_ALL, OP_DIV, R_IM2, R_ONE, R_BM);
      7'd44: i = mk(C_ALL, OP_ADD, R_TOT, R_IM1, R_IM2);
      7'd45: i = mk(C_ALL, OP_PASS, R_V0X, R_AVX, R_ZERO);
      7'd46: i = mk(C_ALL, OP_PASS, R_V0Y, R_AVY, R_ZERO);
      7'd47: i = mk(C_ALL, OP_PASS, R_V1X, R_BVX, R_ZERO);
      7'd48: i = mk(C_ALL, OP_PASS, R_V1Y, R_BVY, R_ZERO);
      7'd49: i = mk(C_ALL, OP_PASS, R_M0X, R_ZERO, R_ZERO);
      7'd50: i = mk(C_ALL, OP_PASS, R_M0Y, R_ZERO, R_ZERO);
      7'd51: i = mk(C_ALL, OP_PASS, R_M1X, R_ZERO, R_ZERO);
      7'd52: i = mk(C_ALL, OP_PASS, R_M1Y, R_ZERO, R_ZERO);
      // separating velocity
      7'd53: i = mk(C_ALL, OP_SUB, R_T0, R_AVX, R_BVX);
      7'd54: i = mk(C_ALL, OP_MUL, R_T0, R_T0, R_NX);
      7'd55: i = mk(C_ALL, OP_SUB, R_T1, R_AVY, R_BVY);
      7'd56: i = mk(C_ALL, OP_MUL, R_T1, R_T1, R_NY);
      7'd57: i = mk(C_ALL, OP_ADD, R_SEP, R_T0, R_T1);
      // impulse
      7'd58: i = mk(C_IMP, OP_SUB, R_T0, R_ZERO, R_SEP);
      7'd59: i = mk(C_IMP, OP_MUL, R_T0, R_T0, R_E);
      7'd60: i = mk(C_IMP, OP_SUB, R_T0, R_T0, R_SEP);
      7'd61: i = mk(C_IMP, OP_DIV, R_T0, R_T0, R_TOT);
      7'd62: i = mk(C_IMP, OP_MUL, R_T1, R_NX, R_T0);
      7'd63: i = mk(C_IMP, OP_MUL, R_T2, R_NY, R_T0);
      7'd64: i = mk(C_IMP_AK1, OP_MUL, R_T0, R_T1, R_IM1);
      7'd65: i = mk(C_IMP_AK1, OP_ADD, R_V0X, R_V0X, R_T0);
      7'd66: i = mk(C_IMP_AK1, OP_MUL, R_T0, R_T2, R_IM1);
      7'd67: i = mk(C_IMP_AK1, OP_ADD, R_V0Y, R_V0Y, R_T0);
      7'd68: i = mk(C_IMP_BK1, OP_MUL, R_T0, R_T1, R_IM2);
      7'd69: i = mk(C_IMP_BK1, OP_SUB, R_V1X, R_V1X, R_T0);
      7'd70: i = mk(C_IMP_BK1, OP_MUL, R_T0, R_T2, R_IM2);
      7'd71: i = mk(C_IMP_BK1, OP_SUB, R_V1Y, R_V1Y, R_T0);
      7'd72: i = mk(C_IMP_AK0, OP_MUL, R_T0, R_T1, R_IM1);
      7'd73: i = mk(C_IMP_AK0, OP_SUB, R_V1X, R_V1X, R_T0);
      7'd74: i = mk(C_IMP_AK0, OP_MUL, R_T0, R_T2, R_IM1);
      7'd75: i = mk(C_IMP_AK0, OP_SUB, R_V1Y, R_V1Y, R_T0);
      7'd76: i = mk(C_IMP_BK0, OP_MUL, R_T0, R_T1, R_IM2);
      7'd77: i = mk(C_IMP_BK0, OP_ADD, R_V0X, R_V0X, R_T0);
      7'd78: i = mk(C_IMP_BK0, OP_MUL, R_T0, R_T2, R_IM2);
      7'd79: i = mk(C_IMP_BK0, OP_ADD, R_V0Y, R_V0Y, R_T0);
      // position correction
      7'd80: i = mk(C_COR, OP_DIV, R_T0, R_PEN, R_TOT);
      7'd81: i = mk(C_COR, OP_MUL, R_T1, R_NX, R_T0);
      7'd82: i = mk(C_COR, OP_MUL, R_T2, R_NY, R_T0);
      7'd83: i = mk(C_COR_AK1, OP_MUL, R_M0X, R_T1, R_IM1);
      7'd84: i = mk(C_COR_AK1, OP_MUL, R_M0Y, R_T2, R_IM1);
      7'd85: i = mk(C_COR_BK1, OP_MUL, R_T0, R_T1, R_IM2);
      7'd86: i = mk(C_COR_BK1, OP_SUB, R_M1X, R_ZERO, R_T0);
      7'd87: i = mk(C_COR_BK1, OP_MUL, R_T0, R_T2, R_IM2);
      7'd88: i = mk(C_COR_BK1, OP_SUB, R_M1Y, R_ZERO, R_T0);
      default: i = mk(C_ALL, OP_PASS, R_T0, R_T0, R_ZERO);
    endcase
    return i;
  endfunction

endpackage
`default_nettype wire

>>> sv/cir_alu.sv
// shared bit-serial arithmetic unit: saturating add/sub, min/max, multiply, divide, length
`default_nettype none
module cir_alu import cir_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  alu_req_t                    req,
  input  logic signed [WORD_BITS-1:0] a,
  input  logic signed [WORD_BITS-1:0] b,
  output alu_stat_t                   stat,
  output logic signed [WORD_BITS-1:0] y
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int CW = $clog2(W + F + 1);
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [PW:0] HALF = {{(W+1){1'b0}}, 1'b1, {(W-1){1'b0}}};
  localparam logic [PW:0] RND  = {{(PW-F+1){1'b0}}, 1'b1, {(F-1){1'b0}}};

  alu_state_t st, st_next;

  logic [PW-1:0]  acc, mc, rad;
  logic [W-1:0]   mr, bsq, root, dd, drem;
  logic [W+1:0]   rrem;
  logic [W+F-1:0] dquo;
  logic [CW-1:0]  cnt;
  logic           neg, done;

  logic [PW-1:0]  accn;
  logic [W+3:0]   rem2, trial;
  logic           sq_ge;
  logic [W-1:0]   rootn;
  logic [W+1:0]   rremn;
  logic [W:0]     r2;
  logic           d_ge;
  logic [W-1:0]   dremn;
  logic [W+F-1:0] dquon;
  logic           last;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    return v[W-1] ? (W'(~v) + W'(1)) : W'(v);
  endfunction

  function automatic logic signed [W-1:0] satmag(input logic [PW:0] q, input logic n);
    logic signed [W-1:0] r;
    if (n) r = (q >= HALF) ? WMIN : W'(-q[W-1:0]);
    else   r = (q > {{(W+1){1'b0}}, WMAX}) ? WMAX : q[W-1:0];
    return r;
  endfunction

  function automatic logic signed [W-1:0] sat1(input logic [W:0] s);
    logic signed [W-1:0] r;
    if (s[W] != s[W-1]) r = s[W] ? WMIN : WMAX;
    else                r = s[W-1:0];
    return r;
  endfunction

  // one step of each serial algorithm
  always_comb begin
    accn  = mr[0] ? (acc + mc) : acc;
    rem2  = {rrem, rad[PW-1:PW-2]};
    trial = {2'b00, root, 2'b01};
    sq_ge = rem2 >= trial;
    rootn = {root[W-2:0], sq_ge};
    rremn = sq_ge ? (W+2)'(rem2 - trial) : rem2[W+1:0];
    r2    = {drem, dquo[W+F-1]};
    d_ge  = r2 >= {1'b0, dd};
    dremn = d_ge ? W'(r2 - {1'b0, dd}) : r2[W-1:0];
    dquon = {dquo[W+F-2:0], d_ge};
    case (st)
      A_DIV:   last = cnt == CW'(W + F - 1);
      default: last = cnt == CW'(W - 1);
    endcase
  end

  always_comb begin
    st_next = st;
    unique case (st)
      A_IDLE: begin
        if (req.start) begin
          unique case (req.op)
            OP_MUL:  st_next = A_MUL;
            OP_LEN:  st_next = A_SQ1;
            OP_DIV:  st_next = (b == '0) ? A_IDLE : A_DIV;
            default: st_next = A_IDLE;
          endcase
        end
      end
      A_MUL:   if (last) st_next = A_IDLE;
      A_SQ1:   if (last) st_next = A_SQ2;
      A_SQ2:   if (last) st_next = A_SQRT;
      A_SQRT:  if (last) st_next = A_IDLE;
      A_DIV:   if (last) st_next = A_IDLE;
      default: st_next = A_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = st != A_IDLE;
    stat.done = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= A_IDLE;
      done <= 1'b0;
    end else begin
      st   <= st_next;
      done <= 1'b0;
      case (st)
        A_IDLE: begin
          if (req.start) begin
            cnt <= '0;
            neg <= a[W-1] ^ b[W-1];
            case (req.op)
              OP_PASS: begin y <= a; done <= 1'b1; end
              OP_ADD:  begin y <= sat1({a[W-1], a} + {b[W-1], b}); done <= 1'b1; end
              OP_SUB:  begin y <= sat1({a[W-1], a} - {b[W-1], b}); done <= 1'b1; end
              OP_MIN:  begin y <= (a < b) ? a : b; done <= 1'b1; end
              OP_MAX:  begin y <= (a > b) ? a : b; done <= 1'b1; end
              OP_MUL: begin
                acc <= '0;
                mc  <= PW'(mag(a));
                mr  <= mag(b);
              end
              OP_LEN: begin
                acc <= '0;
                mc  <= PW'(mag(a));
                mr  <= mag(a);
                bsq <= mag(b);
              end
              OP_DIV: begin
                if (b == '0) begin
                  y    <= a[W-1] ? WMIN : WMAX;
                  done <= 1'b1;
                end
                dquo <= {mag(a), {F{1'b0}}};
                drem <= '0;
                dd   <= mag(b);
              end
              default: ;
            endcase
          end
        end
        A_MUL, A_SQ1, A_SQ2: begin
          acc <= accn;
          mc  <= mc << 1;
          mr  <= mr >> 1;
          cnt <= cnt + CW'(1);
          if (last) begin
            cnt <= '0;
            if (st == A_MUL) begin
              y    <= satmag(({1'b0, accn} + RND) >> F, neg);
              done <= 1'b1;
            end else if (st == A_SQ1) begin
              mc <= PW'(bsq);
              mr <= bsq;
            end else begin
              rad  <= accn;
              rrem <= '0;
              root <= '0;
            end
          end
        end
        A_SQRT: begin
          rrem <= rremn;
          root <= rootn;
          rad  <= rad << 2;
          cnt  <= cnt + CW'(1);
          if (last) begin
            y    <= rootn[W-1] ? WMAX : rootn;
            done <= 1'b1;
          end
        end
        A_DIV: begin
          drem <= dremn;
          dquo <= dquon;
          cnt  <= cnt + CW'(1);
          if (last) begin
            y    <= satmag((PW+1)'(dquon) + (PW+1)'({dremn, 1'b0} >= {1'b0, dd}), neg);
            done <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/contact_impulse_resolver_core.sv
// top level: pair capture, microcode sequencer, scratch registers and result register
//
// usage
// - input channel (in_valid / in_stall): one item per body; body_slot 0 is held,
//   body_slot 1 completes the pair and starts the solve; a slot 1 item with
//   nothing held is taken and dropped, and a second slot 0 item replaces the held one
// - output channel (out_valid / out_stall): one item per completed pair with the
//   contact normal, penetration, new velocities and position corrections
// - a solve runs an 89-step microprogram on one shared bit-serial unit (add, sub,
//   min, max, multiply, divide and length); a step whose condition fails is skipped
// - throughput: one pair per solve; in_stall is high for the whole solve
// - the result register frees the sequencer: slot 0 items are taken while a
//   finished result waits, and a new solve only stalls at its end if the
//   previous result has still not been taken
// - reset (rst, synchronous): drops the held body, the pending result and any solve
`default_nettype none
module contact_impulse_resolver_core import cir_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               body_slot,
  input  logic               shape_kind,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic [30:0]        half_width,
  input  logic [30:0]        half_height,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic [30:0]        mass,
  input  logic [16:0]        restitution,
  input  logic [1:0]         body_kind,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] normal_x,
  output logic signed [17:0] normal_y,
  output logic signed [31:0] penetration,
  output logic signed [31:0] first_vel_x,
  output logic signed [31:0] first_vel_y,
  output logic signed [31:0] second_vel_x,
  output logic signed [31:0] second_vel_y,
  output logic signed [31:0] first_move_x,
  output logic signed [31:0] first_move_y,
  output logic signed [31:0] second_move_x,
  output logic signed [31:0] second_move_y
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int UP = (F >= 16) ? F - 16 : 0;
  localparam int DN = (F >= 16) ? 0 : 16 - F;
  localparam logic signed [63:0] WMAX_L = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic signed [63:0] WMIN_L = -WMAX_L - 64'sd1;
  localparam logic signed [W-1:0] ONE_W  = W'(64'sd1 <<< F);
  localparam logic signed [W-1:0] MONE_W = W'(-(64'sd1 <<< F));

  // one body, already converted to the internal word
  typedef struct packed {
    logic                shape;
    logic [1:0]          kind;
    logic signed [W-1:0] cx, cy, hw, hh, vx, vy, m, e;
  } body_t;

  // microprogram scratch and result registers
  typedef struct packed {
    logic signed [W-1:0] dx, dy, t0, t1, t2, len, nx, ny, pen, e;
    logic signed [W-1:0] im1, im2, tot, sep;
    logic signed [W-1:0] v0x, v0y, v1x, v1y, m0x, m0y, m1x, m1y;
  } scr_t;

  function automatic logic signed [W-1:0] sat64(input logic signed [63:0] v);
    logic signed [W-1:0] r;
    if (v > WMAX_L)      r = W'(WMAX_L);
    else if (v < WMIN_L) r = W'(WMIN_L);
    else                 r = W'(v);
    return r;
  endfunction

  seq_state_t state, state_next;
  logic [PC_BITS-1:0] pc;
  logic    holding;
  body_t   held, cur, in_body;
  scr_t    scr, scr_next;
  instr_t  ins;
  logic    cond_ok, in_fire, pair_go, wb, load_out;
  logic    cc, rr, rc, crx, lenpos, xlt, imp, cor;
  logic signed [W-1:0] opa, opb, alu_y;
  alu_req_t  alu_req;
  alu_stat_t alu_stat;

  // field conversion on the way in (saturate to the word, rescale restitution)
  always_comb begin
    in_body.shape = shape_kind;
    in_body.kind  = body_kind;
    in_body.cx    = sat64(64'(center_x));
    in_body.cy    = sat64(64'(center_y));
    in_body.hw    = sat64(64'(half_width));
    in_body.hh    = sat64(64'(half_height));
    in_body.vx    = sat64(64'(vel_x));
    in_body.vy    = sat64(64'(vel_y));
    in_body.m     = sat64(64'(mass));
    in_body.e     = sat64((64'(restitution) << UP) >> DN);
  end

  assign in_fire = in_valid && !in_stall;
  assign pair_go = in_fire && body_slot && holding;
  assign ins     = prog_at(pc);

  // pair classification and branch flags for conditional steps
  always_comb begin
    cc     = !held.shape && !cur.shape;
    rr     = held.shape && cur.shape;
    rc     = held.shape && !cur.shape;
    crx    = held.shape ^ cur.shape;
    lenpos = scr.len > 0;
    xlt    = scr.t0 < scr.t1;
    imp    = (scr.sep <= 0) && (scr.tot > 0);
    cor    = (scr.pen > 0) && (scr.tot > 0);
    case (ins.cond)
      C_ALL:     cond_ok = 1'b1;
      C_CC:      cond_ok = cc;
      C_CR:      cond_ok = crx;
      C_RC:      cond_ok = rc;
      C_RR:      cond_ok = rr;
      C_LENPOS:  cond_ok = !rr && lenpos;
      C_LENZ:    cond_ok = !rr && !lenpos;
      C_RRX:     cond_ok = rr && xlt;
      C_RRY:     cond_ok = rr && !xlt;
      C_IMP:     cond_ok = imp;
      C_IMP_AK1: cond_ok = imp && (held.kind == KIND_DYNAMIC);
      C_IMP_BK1: cond_ok = imp && (cur.kind == KIND_DYNAMIC);
      C_IMP_AK0: cond_ok = imp && (held.kind == KIND_STATIC);
      C_IMP_BK0: cond_ok = imp && (cur.kind == KIND_STATIC);
      C_COR:     cond_ok = cor;
      C_COR_AK1: cond_ok = cor && (held.kind == KIND_DYNAMIC);
      C_COR_BK1: cond_ok = cor && (cur.kind == KIND_DYNAMIC);
      default:   cond_ok = 1'b0;
    endcase
  end

  // operand select; circle/rectangle roles swap when the rectangle came first
  function automatic logic signed [W-1:0] src(input sel_t s, input body_t a, input body_t b,
                                              input scr_t r, input logic swap);
    logic signed [W-1:0] v;
    case (s)
      R_ZERO:  v = '0;
      R_ONE:   v = ONE_W;
      R_SGNX:  v = (r.dx > 0) ? ONE_W : MONE_W;
      R_SGNY:  v = (r.dy > 0) ? ONE_W : MONE_W;
      R_AX:    v = a.cx;
      R_AY:    v = a.cy;
      R_AHW:   v = a.hw;
      R_AHH:   v = a.hh;
      R_AVX:   v = a.vx;
      R_AVY:   v = a.vy;
      R_AM:    v = a.m;
      R_AE:    v = a.e;
      R_BX:    v = b.cx;
      R_BY:    v = b.cy;
      R_BHW:   v = b.hw;
      R_BHH:   v = b.hh;
      R_BVX:   v = b.vx;
      R_BVY:   v = b.vy;
      R_BM:    v = b.m;
      R_BE:    v = b.e;
      R_CX:    v = swap ? b.cx : a.cx;
      R_CY:    v = swap ? b.cy : a.cy;
      R_CHW:   v = swap ? b.hw : a.hw;
      R_RX:    v = swap ? a.cx : b.cx;
      R_RY:    v = swap ? a.cy : b.cy;
      R_RHW:   v = swap ? a.hw : b.hw;
      R_RHH:   v = swap ? a.hh : b.hh;
      R_DX:    v = r.dx;
      R_DY:    v = r.dy;
      R_T0:    v = r.t0;
      R_T1:    v = r.t1;
      R_T2:    v = r.t2;
      R_LEN:   v = r.len;
      R_NX:    v = r.nx;
      R_NY:    v = r.ny;
      R_PEN:   v = r.pen;
      R_E:     v = r.e;
      R_IM1:   v = r.im1;
      R_IM2:   v = r.im2;
      R_TOT:   v = r.tot;
      R_SEP:   v = r.sep;
      R_V0X:   v = r.v0x;
      R_V0Y:   v = r.v0y;
      R_V1X:   v = r.v1x;
      R_V1Y:   v = r.v1y;
      R_M0X:   v = r.m0x;
      R_M0Y:   v = r.m0y;
      R_M1X:   v = r.m1x;
      R_M1Y:   v = r.m1y;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign opa = src(ins.sa, held, cur, scr, rc);
  assign opb = src(ins.sb, held, cur, scr, rc);

  cir_alu #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (alu_req),
    .a    (opa),
    .b    (opb),
    .stat (alu_stat),
    .y    (alu_y)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (pair_go) state_next = S_ISSUE;
      S_ISSUE: begin
        if (cond_ok)               state_next = S_WAIT;
        else if (pc == PROG_LAST)  state_next = S_FINISH;
      end
      S_WAIT: begin
        if (alu_stat.done) state_next = (pc == PROG_LAST) ? S_FINISH : S_ISSUE;
      end
      S_FINISH: if (!out_valid || !out_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall      = state != S_IDLE;
    alu_req.start = (state == S_ISSUE) && cond_ok;
    alu_req.op    = ins.op;
    wb            = (state == S_WAIT) && alu_stat.done;
    load_out      = (state == S_FINISH) && (!out_valid || !out_stall);
  end

  // write back of the unit result into the named scratch register
  always_comb begin
    scr_next = scr;
    if (wb) begin
      case (ins.dst)
        R_DX:    scr_next.dx  = alu_y;
        R_DY:    scr_next.dy  = alu_y;
        R_T0:    scr_next.t0  = alu_y;
        R_T1:    scr_next.t1  = alu_y;
        R_T2:    scr_next.t2  = alu_y;
        R_LEN:   scr_next.len = alu_y;
        R_NX:    scr_next.nx  = alu_y;
        R_NY:    scr_next.ny  = alu_y;
        R_PEN:   scr_next.pen = alu_y;
        R_E:     scr_next.e   = alu_y;
        R_IM1:   scr_next.im1 = alu_y;
        R_IM2:   scr_next.im2 = alu_y;
        R_TOT:   scr_next.tot = alu_y;
        R_SEP:   scr_next.sep = alu_y;
        R_V0X:   scr_next.v0x = alu_y;
        R_V0Y:   scr_next.v0y = alu_y;
        R_V1X:   scr_next.v1x = alu_y;
        R_V1Y:   scr_next.v1y = alu_y;
        R_M0X:   scr_next.m0x = alu_y;
        R_M0Y:   scr_next.m0y = alu_y;
        R_M1X:   scr_next.m1x = alu_y;
        R_M1Y:   scr_next.m1y = alu_y;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    scr <= scr_next;
    if (in_fire && !body_slot) held <= in_body;
    if (pair_go) cur <= in_body;
    if (load_out) begin
      normal_x      <= 18'(scr.nx);
      normal_y      <= 18'(scr.ny);
      penetration   <= 32'(scr.pen);
      first_vel_x   <= 32'(scr.v0x);
      first_vel_y   <= 32'(scr.v0y);
      second_vel_x  <= 32'(scr.v1x);
      second_vel_y  <= 32'(scr.v1y);
      first_move_x  <= 32'(scr.m0x);
      first_move_y  <= 32'(scr.m0y);
      second_move_x <= 32'(scr.m1x);
      second_move_y <= 32'(scr.m1y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      holding   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // slot 0 always (re)loads the held body, a completed pair releases it
      if (in_fire && !body_slot) holding <= 1'b1;
      else if (pair_go)          holding <= 1'b0;
      if (state == S_IDLE)                       pc <= '0;
      else if ((state == S_ISSUE) && !cond_ok)   pc <= pc + PC_BITS'(1);
      else if (wb)                               pc <= pc + PC_BITS'(1);
      if (load_out)                    out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // the unit is only started when it has finished the previous step
  a_start_free: assert property (@(posedge clk) disable iff (rst)
    alu_req.start |-> !alu_stat.busy)
    else $error("unit started while busy");

  // a completed pair releases the held body
  a_pair_release: assert property (@(posedge clk) disable iff (rst)
    pair_go |=> !holding)
    else $error("held body kept after pair");

  // no solve starts without a completed pair
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && !pair_go |=> (state == S_IDLE))
    else $error("solve started without a pair");

  // unit results only arrive while the sequencer waits for them
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    alu_stat.done |-> (state == S_WAIT))
    else $error("unit result outside wait state");

endmodule
`default_nettype wire

>>> bench/contact_impulse_resolver_checker.sv
// checker for the contact impulse resolver: predicts each pair result and compares it
`default_nettype none
module contact_impulse_resolver_checker import cir_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               body_slot,
  input  logic               shape_kind,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic [30:0]        half_width,
  input  logic [30:0]        half_height,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic [30:0]        mass,
  input  logic [16:0]        restitution,
  input  logic [1:0]         body_kind,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [17:0] normal_x,
  input  logic signed [17:0] normal_y,
  input  logic signed [31:0] penetration,
  input  logic signed [31:0] first_vel_x,
  input  logic signed [31:0] first_vel_y,
  input  logic signed [31:0] second_vel_x,
  input  logic signed [31:0] second_vel_y,
  input  logic signed [31:0] first_move_x,
  input  logic signed [31:0] first_move_y,
  input  logic signed [31:0] second_move_x,
  input  logic signed [31:0] second_move_y,
  output int                 mismatches,
  output int                 waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint WMAX  = 64'sd2147483647;
  localparam longint WMIN  = -64'sd2147483648;
  localparam longint ONE   = 64'sd65536;
  localparam logic [127:0] BIG62 = 128'd1 << 62;

  typedef logic [127:0] wide_t;
  typedef logic [10:0][31:0] contact_t;

  typedef struct {
    logic       shape;
    logic [1:0] kind;
    longint     cx, cy, hw, hh, vx, vy, m, e;
  } body_t;

  contact_t expected_contacts[$];
  body_t    held_body;
  logic     holding;

  function automatic longint sat(longint v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return v;
  endfunction

  function automatic wide_t mag(longint a);
    return wide_t'(a < 0 ? -a : a);
  endfunction

  function automatic longint signed_clip(wide_t q, logic neg);
    if (q > BIG62) q = BIG62;
    return sat(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic longint fmul(longint a, longint b);
    wide_t p;
    p = mag(a) * mag(b) + (wide_t'(1) << 15);
    return signed_clip(p >> 16, (a < 0) != (b < 0));
  endfunction

  function automatic longint fdiv(longint a, longint b);
    wide_t num, d, q, r;
    logic over;
    if (b == 0) return a >= 0 ? WMAX : WMIN;
    num = mag(a) << 16;
    d = mag(b);
    q = num / d;
    r = num % d;
    over = q >= BIG62;
    if (r * 2 >= d) q = q + 1;
    if (over) q = BIG62;
    return signed_clip(q, (a < 0) != (b < 0));
  endfunction

  function automatic longint flen(longint dx, longint dy);
    wide_t s, r, c;
    s = mag(dx) * mag(dx) + mag(dy) * mag(dy);
    r = 0;
    for (int bit_i = 48; bit_i >= 0; bit_i--) begin
      c = r | (wide_t'(1) << bit_i);
      if (c * c <= s) r = c;
    end
    return sat(longint'(r));
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // normal from an offset, straight up when the offset vanishes
  function automatic void to_unit(longint dx, longint dy, longint len,
                                  output longint nx, output longint ny);
    if (len > 0) begin
      nx = fdiv(dx, len);
      ny = fdiv(dy, len);
    end else begin
      nx = 0;
      ny = ONE;
    end
  endfunction

  function automatic void circle_box(body_t c, body_t r, output longint nx,
                                     output longint ny, output longint pen);
    longint px, py, dx, dy, len;
    px = clip(c.cx, sat(r.cx - r.hw), sat(r.cx + r.hw));
    py = clip(c.cy, sat(r.cy - r.hh), sat(r.cy + r.hh));
    dx = sat(c.cx - px);
    dy = sat(c.cy - py);
    len = flen(dx, dy);
    pen = sat(c.hw - len);
    to_unit(dx, dy, len, nx, ny);
  endfunction

  function automatic body_t take_body(logic shp, logic signed [31:0] x, logic signed [31:0] y,
                                      logic [30:0] w, logic [30:0] h, logic signed [31:0] u,
                                      logic signed [31:0] v, logic [30:0] m, logic [16:0] e,
                                      logic [1:0] k);
    body_t b;
    b.shape = shp;
    b.kind  = k;
    b.cx = longint'(x);
    b.cy = longint'(y);
    b.hw = longint'({33'd0, w});
    b.hh = longint'({33'd0, h});
    b.vx = longint'(u);
    b.vy = longint'(v);
    b.m  = longint'({33'd0, m});
    b.e  = longint'({47'd0, e});
    return b;
  endfunction

  function automatic contact_t resolve_contact(body_t a, body_t b);
    longint nx, ny, pen, dx, dy, len, px, py, e, im1, im2, tot, sep;
    longint v0x, v0y, v1x, v1y, m0x, m0y, m1x, m1y, dv, imp, jx, jy, s, cx, cy;
    contact_t res;
    m0x = 0; m0y = 0; m1x = 0; m1y = 0;
    dx = sat(a.cx - b.cx);
    dy = sat(a.cy - b.cy);
    if (!a.shape && !b.shape) begin
      len = flen(dx, dy);
      to_unit(dx, dy, len, nx, ny);
      pen = sat(sat(a.hw + b.hw) - len);
    end else if (!a.shape) begin
      circle_box(a, b, nx, ny, pen);
    end else if (!b.shape) begin
      // solved circle first, then flipped back to input order
      circle_box(b, a, nx, ny, pen);
      nx = sat(-nx);
      ny = sat(-ny);
    end else begin
      px = sat(sat(a.hw + b.hw) - (dx < 0 ? sat(-dx) : dx));
      py = sat(sat(a.hh + b.hh) - (dy < 0 ? sat(-dy) : dy));
      if (px < py) begin
        pen = px; nx = dx > 0 ? ONE : -ONE; ny = 0;
      end else begin
        pen = py; nx = 0; ny = dy > 0 ? ONE : -ONE;
      end
    end
    e = fdiv(sat(fmul(a.m, a.e) + fmul(b.m, b.e)), sat(a.m + b.m));
    im1 = fdiv(ONE, a.m);
    im2 = fdiv(ONE, b.m);
    tot = sat(im1 + im2);
    v0x = a.vx; v0y = a.vy; v1x = b.vx; v1y = b.vy;
    sep = sat(fmul(sat(a.vx - b.vx), nx) + fmul(sat(a.vy - b.vy), ny));
    if (sep <= 0 && tot > 0) begin
      dv = sat(fmul(sat(-sep), e) - sep);
      imp = fdiv(dv, tot);
      jx = fmul(nx, imp);
      jy = fmul(ny, imp);
      if (a.kind == KIND_DYNAMIC) begin
        v0x = sat(v0x + fmul(jx, im1)); v0y = sat(v0y + fmul(jy, im1));
      end
      if (b.kind == KIND_DYNAMIC) begin
        v1x = sat(v1x - fmul(jx, im2)); v1y = sat(v1y - fmul(jy, im2));
      end
      if (a.kind == KIND_STATIC) begin
        v1x = sat(v1x - fmul(jx, im1)); v1y = sat(v1y - fmul(jy, im1));
      end
      if (b.kind == KIND_STATIC) begin
        v0x = sat(v0x + fmul(jx, im2)); v0y = sat(v0y + fmul(jy, im2));
      end
    end
    if (pen > 0 && tot > 0) begin
      s = fdiv(pen, tot);
      cx = fmul(nx, s);
      cy = fmul(ny, s);
      if (a.kind == KIND_DYNAMIC) begin
        m0x = fmul(cx, im1); m0y = fmul(cy, im1);
      end
      if (b.kind == KIND_DYNAMIC) begin
        m1x = sat(-fmul(cx, im2)); m1y = sat(-fmul(cy, im2));
      end
    end
    res[0]  = 32'(nx) & 32'h3FFFF;
    res[1]  = 32'(ny) & 32'h3FFFF;
    res[2]  = 32'(pen);
    res[3]  = 32'(v0x);
    res[4]  = 32'(v0y);
    res[5]  = 32'(v1x);
    res[6]  = 32'(v1y);
    res[7]  = 32'(m0x);
    res[8]  = 32'(m0y);
    res[9]  = 32'(m1x);
    res[10] = 32'(m1y);
    return res;
  endfunction

  assign waiting = expected_contacts.size();

  always_ff @(posedge clk) begin
    body_t    incoming;
    contact_t got, want;
    if (rst) begin
      holding <= 1'b0;
      mismatches <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        incoming = take_body(shape_kind, center_x, center_y, half_width, half_height,
                             vel_x, vel_y, mass, restitution, body_kind);
        if (!body_slot) begin
          held_body <= incoming;
          holding <= 1'b1;
        end else if (holding) begin
          expected_contacts.push_back(resolve_contact(held_body, incoming));
          holding <= 1'b0;
        end
      end
      if (out_valid && !out_stall) begin
        got = {32'(second_move_y), 32'(second_move_x), 32'(first_move_y), 32'(first_move_x),
               32'(second_vel_y), 32'(second_vel_x), 32'(first_vel_y), 32'(first_vel_x),
               32'(penetration), {14'd0, normal_y}, {14'd0, normal_x}};
        if (expected_contacts.size() == 0) begin
          if (mismatches < 10) $display("unexpected result item %h", got);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_contacts.pop_front();
          for (int f = 0; f < 11; f++) begin
            if (got[f] !== want[f]) begin
              if (mismatches < 10)
                $display("field %0d mismatch: expected %h got %h", f, want[f], got[f]);
              mismatches <= mismatches + 1;
              break;
            end
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> bench/contact_impulse_resolver_core_test.sv
// stimulus and verdict for the contact impulse resolver core
`default_nettype none
module contact_impulse_resolver_core_test import cir_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  ONE_Q     = 65536;
  localparam int  RAND_BODIES = 1650;
  localparam longint CYCLE_LIMIT = 64'd8000000;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic body_slot, shape_kind;
  logic signed [31:0] center_x, center_y, vel_x, vel_y;
  logic [30:0] half_width, half_height, mass;
  logic [16:0] restitution;
  logic [1:0]  body_kind;
  logic signed [17:0] normal_x, normal_y;
  logic signed [31:0] penetration, first_vel_x, first_vel_y, second_vel_x, second_vel_y;
  logic signed [31:0] first_move_x, first_move_y, second_move_x, second_move_y;
  int mismatches, waiting;
  longint cycles;
  int burst_left;
  int sent;

  contact_impulse_resolver_core DUT (.*);
  contact_impulse_resolver_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run-away guard
  always_ff @(posedge clk) begin
    cycles <= rst ? 64'd0 : cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stall: the mode is redrawn whenever the phase counter wraps, from never stalling
  // to stalling most of the time
  logic [1:0]  stall_mode;
  logic [11:0] stall_phase;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_mode <= 2'd0;
      stall_phase <= '0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase == '1) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(0, 3) == 0);
        2'd2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (stall_phase[2:0] < 3'd3);
      endcase
    end
  end

  // one body item; the sender keeps valid up inside a burst and drops it in a gap
  task automatic put_body(logic slot, logic shp, logic signed [31:0] x, logic signed [31:0] y,
                          logic [30:0] w, logic [30:0] h, logic signed [31:0] u,
                          logic signed [31:0] v, logic [30:0] m, logic [16:0] e,
                          logic [1:0] k);
    body_slot <= slot; shape_kind <= shp;
    center_x <= x; center_y <= y; half_width <= w; half_height <= h;
    vel_x <= u; vel_y <= v; mass <= m; restitution <= e; body_kind <= k;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // signed value: mostly near the origin so shapes overlap, sometimes wild
  function automatic logic [31:0] pick_signed(int span);
    case ($urandom_range(0, 11))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  function automatic logic [30:0] pick_size(int span);
    case ($urandom_range(0, 11))
      0: return 31'($urandom);
      1: return 31'h7FFF_FFFF;
      2: return '0;
      default: return 31'($urandom_range(0, span));
    endcase
  endfunction

  function automatic logic [30:0] pick_mass();
    logic [30:0] m;
    case ($urandom_range(0, 9))
      0: m = 31'($urandom);
      1: m = 31'h7FFF_FFFF;
      2: m = 31'd1;
      default: m = 31'($urandom_range(ONE_Q / 8, 16 * ONE_Q));
    endcase
    return m == 0 ? 31'd1 : m;
  endfunction

  task automatic put_random(logic slot);
    put_body(slot, 1'($urandom), pick_signed(6 * ONE_Q), pick_signed(6 * ONE_Q),
             pick_size(3 * ONE_Q), pick_size(3 * ONE_Q),
             pick_signed(5 * ONE_Q), pick_signed(5 * ONE_Q), pick_mass(),
             ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, ONE_Q)),
             2'($urandom_range(0, 2)));
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    body_slot = 1'b0; shape_kind = 1'b0;
    center_x = '0; center_y = '0; half_width = '0; half_height = '0;
    vel_x = '0; vel_y = '0; mass = 31'd1; restitution = '0; body_kind = '0;
    burst_left = 0;
    sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // lone second body with nothing held
    put_body(1'b1, 1'b0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q, 0, KIND_DYNAMIC);
    // circles on the same center, held body replaced first
    put_body(1'b0, 1'b1, 5, 5, 1, 1, 0, 0, 1, 0, KIND_STATIC);
    put_body(1'b0, 1'b0, 0, 0, ONE_Q, 0, ONE_Q, 0, ONE_Q, 17'd65536, KIND_DYNAMIC);
    put_body(1'b1, 1'b0, 0, 0, ONE_Q, 0, -ONE_Q, 0, 2 * ONE_Q, 17'd0, KIND_DYNAMIC);
    // circle against rectangle, approaching
    put_body(1'b0, 1'b0, 2 * ONE_Q, ONE_Q / 2, ONE_Q, 0, -ONE_Q, 0, ONE_Q, 17'd32768,
             KIND_DYNAMIC);
    put_body(1'b1, 1'b1, 0, 0, ONE_Q + ONE_Q / 2, ONE_Q, 0, 0, ONE_Q, 17'd32768, KIND_STATIC);
    // rectangle then circle, bodies separating
    put_body(1'b0, 1'b1, 0, 0, ONE_Q, ONE_Q, -ONE_Q, 0, ONE_Q, 17'd65536, KIND_DYNAMIC);
    put_body(1'b1, 1'b0, ONE_Q + ONE_Q / 2, 0, ONE_Q, 0, ONE_Q, 0, ONE_Q, 0, KIND_DYNAMIC);
    // rectangle pair, equal axis overlaps and zero offset
    put_body(1'b0, 1'b1, 0, 0, ONE_Q, ONE_Q, 0, ONE_Q, ONE_Q, 17'd65536, KIND_STATIC);
    put_body(1'b1, 1'b1, 0, 0, ONE_Q, ONE_Q, 0, -ONE_Q, ONE_Q, 17'd65536, KIND_DYNAMIC);
    // rectangle pair overlapping along x, untouched third kind
    put_body(1'b0, 1'b1, ONE_Q, 0, ONE_Q, 4 * ONE_Q, -ONE_Q, 0, 3 * ONE_Q, 17'd1, 2'd2);
    put_body(1'b1, 1'b1, 0, 0, ONE_Q, 4 * ONE_Q, ONE_Q, 0, ONE_Q, 17'd100, KIND_STATIC);
    // field extremes
    put_body(1'b0, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
             32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 17'h1FFFF, 2'd3);
    put_body(1'b1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h8000_0000, 31'd1, 17'h1FFFF, KIND_DYNAMIC);
    put_body(1'b0, 1'b1, 0, 0, 0, 0, 0, 0, 31'd1, 0, KIND_STATIC);
    put_body(1'b1, 1'b0, 0, 0, 0, 0, 0, 0, 31'd1, 0, KIND_STATIC);

    // hold off until the pipeline has drained once
    in_valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);

    // random pairs, with lone second bodies and replaced first bodies as noise
    while (sent < RAND_BODIES) begin
      case ($urandom_range(0, 19))
        0: put_random(1'b1);
        1: begin
          put_random(1'b0);
          put_random(1'b0);
          put_random(1'b1);
        end
        default: begin
          put_random(1'b0);
          put_random(1'b1);
        end
      endcase
      if (sent > 800 && sent < 806) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (waiting != 0);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (2000) @(posedge clk);
    if (mismatches == 0 && waiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
